FILE: rtl/core/omrb_pkg.sv
// package for the overwriting message ring buffer: defaults, field widths and function codes
package omrb_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int SLOT_BYTES_DEF = 32;

  localparam int FUNC_W = 2;
  localparam int BYTE_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

endpackage

FILE: rtl/core/omrb_if.sv
// channel interfaces for the message ring buffer input and result streams
interface omrb_in_if;
  logic                        valid;
  logic                        ready;
  logic [omrb_pkg::FUNC_W-1:0] func;
  logic [omrb_pkg::BYTE_W-1:0] data_byte;
  logic                        last_byte;

  modport source (output valid, output func, output data_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input func, input data_byte, input last_byte,
                  output ready);
endinterface

interface omrb_out_if;
  logic                        valid;
  logic                        ready;
  logic [omrb_pkg::BYTE_W-1:0] out_byte;
  logic                        last_of_message;
  logic                        empty_res;

  modport source (output valid, output out_byte, output last_of_message,
                  output empty_res, input ready);
  modport sink   (input valid, input out_byte, input last_of_message,
                  input empty_res, output ready);
endinterface

FILE: rtl/core/omrb_ram.sv
// generic single-write, single-read ram with registered read data
module omrb_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/overwriting_message_ring_buffer.sv
// Ring of SLOT_COUNT message slots of SLOT_BYTES bytes, overwriting the oldest message when full.
// A push or clear is handled on its accept and leaves the block ready for the next request. A pop that finds
// a queued message takes its accept cycle and then streams the slot out of the byte memory at one
// byte per cycle while the result side takes them, and the block stays busy until the slot's last byte
// is loaded; a pop on an empty ring holds the block until its single result is loaded.
// Both memories are written only by pushes and read only by pops, so no two accesses overlap.
// Bytes past a message's stored length read back as zero, so memory contents need no clearing.
module overwriting_message_ring_buffer #(
  parameter int SLOT_COUNT = omrb_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES = omrb_pkg::SLOT_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  omrb_in_if.sink   in_ch,
  omrb_out_if.source out_ch
);

  import omrb_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int POS_W  = $clog2(SLOT_BYTES + 1);
  localparam int K_W    = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int DEPTH  = SLOT_COUNT * SLOT_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_EMPTY, S_STREAM} state_t;

  state_t             state_r, state_nxt;
  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SLOT_W-1:0]  wslot_r, wslot_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               open_r, open_nxt;
  logic [K_W-1:0]     k_r, k_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_empty_r, out_empty_nxt;

  logic               byte_we, byte_re, len_we, len_re;
  logic [ADDR_W-1:0]  byte_waddr, byte_raddr;
  logic [BYTE_W-1:0]  byte_rdata;
  logic [POS_W-1:0]   len_wdata, len_rdata;
  logic [SLOT_W-1:0]  len_raddr;

  logic               accept, out_free;
  logic [POS_W-1:0]   pos_eff, pos_new;
  logic [SLOT_W-1:0]  head_drop;
  logic [CNT_W-1:0]   count_drop;
  logic               pos_room;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_byte        = out_byte_r;
  assign out_ch.last_of_message = out_last_r;
  assign out_ch.empty_res       = out_empty_r;

  // a new message restarts at byte zero
  assign pos_eff  = open_r ? pos_r : '0;
  assign pos_room = (pos_eff < POS_W'(SLOT_BYTES));
  assign pos_new  = pos_eff + POS_W'(pos_room);

  // oldest message dropped on the first byte into a full ring
  always_comb begin
    head_drop  = head_r;
    count_drop = count_r;
    if (!open_r && (count_r == CNT_W'(SLOT_COUNT))) begin
      head_drop  = next_slot(head_r);
      count_drop = CNT_W'(SLOT_COUNT - 1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    wslot_nxt     = wslot_r;
    pos_nxt       = pos_r;
    open_nxt      = open_r;
    k_nxt         = k_r;
    base_nxt      = base_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;

    byte_we    = 1'b0;
    byte_waddr = ADDR_W'(wslot_r) * ADDR_W'(SLOT_BYTES) + ADDR_W'(pos_eff[K_W-1:0]);
    byte_re    = 1'b0;
    byte_raddr = ADDR_W'(head_r) * ADDR_W'(SLOT_BYTES);
    len_we     = 1'b0;
    len_wdata  = pos_new;
    len_re     = 1'b0;
    len_raddr  = head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.func)
            FUNC_PUSH: begin
              head_nxt  = head_drop;
              count_nxt = count_drop;
              byte_we   = pos_room;
              if (in_ch.last_byte) begin
                len_we    = 1'b1;
                count_nxt = count_drop + 1'b1;
                wslot_nxt = next_slot(wslot_r);
                open_nxt  = 1'b0;
                pos_nxt   = '0;
              end else begin
                open_nxt = 1'b1;
                pos_nxt  = pos_new;
              end
            end
            FUNC_POP: begin
              if (count_r == '0) begin
                state_nxt = S_EMPTY;
              end else begin
                // length and first byte come back together next cycle
                len_re    = 1'b1;
                byte_re   = 1'b1;
                base_nxt  = byte_raddr;
                k_nxt     = '0;
                head_nxt  = next_slot(head_r);
                count_nxt = count_r - 1'b1;
                state_nxt = S_STREAM;
              end
            end
            FUNC_CLEAR: begin
              head_nxt  = '0;
              count_nxt = '0;
              wslot_nxt = '0;
              pos_nxt   = '0;
              open_nxt  = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = '0;
          out_last_nxt  = 1'b0;
          out_empty_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_STREAM: begin
        // read data holds until the next read, so a stall simply waits
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = (POS_W'(k_r) < len_rdata) ? byte_rdata : '0;
          out_last_nxt  = (k_r == K_W'(SLOT_BYTES - 1));
          out_empty_nxt = 1'b0;
          if (k_r == K_W'(SLOT_BYTES - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt      = k_r + 1'b1;
            byte_re    = 1'b1;
            byte_raddr = base_r + ADDR_W'(k_r) + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      wslot_r     <= '0;
      pos_r       <= '0;
      open_r      <= 1'b0;
      k_r         <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
      out_byte_r  <= '0;
      out_last_r  <= 1'b0;
      out_empty_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      wslot_r     <= wslot_nxt;
      pos_r       <= pos_nxt;
      open_r      <= open_nxt;
      k_r         <= k_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
      out_byte_r  <= out_byte_nxt;
      out_last_r  <= out_last_nxt;
      out_empty_r <= out_empty_nxt;
    end
  end

  omrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_byte_ram (
    .clk  (clk),
    .we   (byte_we),
    .waddr(byte_waddr),
    .wdata(in_ch.data_byte),
    .re   (byte_re),
    .raddr(byte_raddr),
    .rdata(byte_rdata)
  );

  omrb_ram #(
    .WIDTH (POS_W),
    .DEPTH (SLOT_COUNT),
    .ADDR_W(SLOT_W)
  ) u_len_ram (
    .clk  (clk),
    .we   (len_we),
    .waddr(wslot_r),
    .wdata(len_wdata),
    .re   (len_re),
    .raddr(len_raddr),
    .rdata(len_rdata)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOT_COUNT))
    else $error("queued message count above slot count");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> (out_byte_r == '0) && !out_last_r)
    else $error("empty pop result carries data");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.func == FUNC_CLEAR) |=> (count_r == '0) && !open_r && (wslot_r == '0))
    else $error("clear left queue state behind");

  a_stream_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STREAM) && out_free && (k_r == K_W'(SLOT_BYTES - 1))
      |=> out_valid_r && out_last_r && (state_r == S_IDLE))
    else $error("slot stream did not end on its last byte");

endmodule
